// File: design/ftsf_pkg.sv
// ----------------------------------------------------------------------------
// ftsf_pkg: shared types and constants
// fixed coefficients, gain limits, register indexes, sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package ftsf_pkg;

    // one-pole coefficients, Q0.16
    localparam logic [15:0] ALPHA_POS  = 16'd7864;
    localparam logic [15:0] ALPHA_NEG  = 16'd5243;

    // gain limits, Q2.14
    localparam logic [15:0] GAIN_MIN   = 16'd8192;
    localparam logic [15:0] GAIN_MAX   = 16'd32768;
    localparam logic [15:0] GAIN_UNITY = 16'd16384;
    localparam logic [15:0] STEP_MAX   = 16'd32768;
    localparam logic [15:0] STEP_RST   = 16'd16;

    // half a semitone in sixteenths
    localparam logic signed [8:0] BYPASS_LIM = 9'sd8;

    // width of the serial multiplier's unsigned operand
    localparam int MUL_B_W = 16;

    typedef enum logic [1:0] {
        CFG_SHIFT       = 2'd0,
        CFG_GAIN_TARGET = 2'd1,
        CFG_RAMP_STEP   = 2'd2,
        CFG_CHANNELS    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_W1,
        ST_LP,
        ST_W2,
        ST_W3,
        ST_FIN
    } state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// File: design/ftsf_smul.sv
// ----------------------------------------------------------------------------
// ftsf_smul: bit-serial multiplier
// signed multiplicand times unsigned multiplier, one multiplier bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ftsf_smul
    import ftsf_pkg::*;
#(
    parameter int WA = 25
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  wire  signed [WA-1:0]          a,
    input  wire         [MUL_B_W-1:0]     b,
    output unit_stat_t                    stat,
    output logic signed [WA+MUL_B_W-1:0]  p
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic signed [WA:0]       hi_reg;
    logic signed [WA:0]       hi_next;
    logic [MUL_B_W-1:0]       lo_reg;
    logic [MUL_B_W-1:0]       lo_next;
    logic signed [WA-1:0]     a_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [WA:0]       sum;

    // partial sum of one step, then shift right by one
    always_comb
    begin
        sum     = hi_reg + (lo_reg[0] ? (WA+1)'(a_reg) : '0);
        hi_next = {sum[WA], sum[WA:1]};
        lo_next = {sum[0], lo_reg[MUL_B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= b;
            a_reg  <= a;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign p         = {hi_reg[WA-1:0], lo_reg};

endmodule

`default_nettype wire

// File: design/ftsf_sdiv.sv
// ----------------------------------------------------------------------------
// ftsf_sdiv: bit-serial reciprocal of the gain
// restoring division of 2^28 + g/2 by g, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ftsf_sdiv
    import ftsf_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  [15:0]         divisor,
    output unit_stat_t          stat,
    output logic [15:0]         quotient
);

    logic [15:0] rem_reg;
    logic [15:0] num_reg;
    logic [15:0] q_reg;
    logic [15:0] d_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic        fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[15]};
        fits  = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // upper numerator bits are 2^12, always below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 16'd4096;
            num_reg <= {1'b0, divisor[15:1]};
            d_reg   <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
            num_reg <= {num_reg[14:0], 1'b0};
            q_reg   <= {q_reg[14:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

`default_nettype wire

// File: design/formant_tilt_shelf_filter_top.sv
// ----------------------------------------------------------------------------
// formant_tilt_shelf_filter_top: per-channel one-pole tilt shelving filter
// splits each sample into low and high bands, weights them by 1/gain and
// gain, ramps the gain toward its target, passes through when settled
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                          payload
//  s_        in         s_tvalid s_tready s_tdata        sample_in [15:0]
//  m_        out        m_tvalid m_tready m_tdata        sample_out [15:0]
//  cfg_      in         cfg_valid cfg_ready cfg_index    register write
//                       cfg_data
//
//  a passed-through sample goes from the idle state straight to the final
//  state, where it is loaded into the output register; a filtered sample takes
//  three 16-step passes of the shared bit-serial multiplier plus sequencing
//  (the reciprocal runs alongside the first one)
//  one sample is in work at a time; s_tready is high only while idle, so the
//  next request waits until the cycle after the output register is loaded
//  a full output register stalls the sequencer in its final state
//  reset clears the channel memories through their valid bits, the gain
//  goes to unity and the channel counter to zero; no clearing pass
//
`default_nettype none

module formant_tilt_shelf_filter_top
    import ftsf_pkg::*;
#(
    parameter int MAX_CHANNELS    = 8,
    parameter int STATE_FRAC_BITS = 8
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,      // [15:0] sample_in

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,      // [15:0] sample_out

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    // widths that follow from the state format
    localparam int F     = STATE_FRAC_BITS;
    localparam int MW    = 16 + F;          // lowpass memory word
    localparam int DW    = MW + 1;          // band difference
    localparam int PW    = DW + MUL_B_W;    // product
    localparam int AW    = PW + 1;          // sum of both products
    localparam int SH    = F + 14;          // output scaling
    localparam int RW    = AW - SH;         // scaled result
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [5:0] MAXC = 6'(MAX_CHANNELS);
    localparam logic signed [AW-1:0] BIAS = AW'((64'd1 << SH) - 64'd1);
    localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

    // configuration registers
    logic signed [8:0]  shift_reg;
    logic [15:0]        target_reg;
    logic [15:0]        step_reg;
    logic [3:0]         chan_reg;

    // channel state
    logic [MW-1:0]           mem_reg   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] valid_reg;
    logic [CW-1:0]           pos_reg;
    logic [15:0]             gain_reg;

    // per-sample working registers
    state_t              state_reg;
    state_t              state_next;
    logic signed [15:0]  x_reg;
    logic [CW-1:0]       c_reg;
    logic signed [MW-1:0] m_reg;
    logic signed [MW-1:0] lp_reg;
    logic                bypass_reg;
    logic [15:0]         alpha_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;

    // output register
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;

    // combinational
    logic [5:0]          nch;
    logic [CW-1:0]       c_now;
    logic [CW-1:0]       pos_after;
    logic [15:0]         target_eff;
    logic [15:0]         step_eff;
    logic                shift_small;
    logic                bypass_now;
    logic [15:0]         gain_new;
    logic [16:0]         gain_gap;
    logic signed [MW-1:0] xs;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] hp;
    logic [DW-1:0]       lp_sum;
    logic signed [AW-1:0] rnd;
    logic signed [RW-1:0] scaled;
    logic [15:0]         sat_out;
    logic                accept;
    logic                out_free;
    logic                cfg_we;

    // serial unit hookup
    logic                mul_start;
    logic signed [DW-1:0] mul_a;
    logic [15:0]         mul_b;
    unit_stat_t          mul_st;
    logic signed [PW-1:0] mul_p;
    logic                div_start;
    unit_stat_t          div_st;
    logic [15:0]         inv;

    function automatic logic [5:0] eff_count(input logic [3:0] cc);
        logic [5:0] v;
        begin
            v = 6'(cc);
            if (v == 6'd0)
                eff_count = 6'd1;
            else if (v > MAXC)
                eff_count = MAXC;
            else
                eff_count = v;
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // channel selection, stale positions restart at zero
    always_comb
    begin
        nch       = eff_count(chan_reg);
        c_now     = (6'(pos_reg) >= nch) ? '0 : pos_reg;
        pos_after = (6'(c_now) + 6'd1 >= nch) ? '0 : CW'(6'(c_now) + 6'd1);
    end

    // register clamps and bypass decision
    always_comb
    begin
        if (target_reg < GAIN_MIN)
            target_eff = GAIN_MIN;
        else if (target_reg > GAIN_MAX)
            target_eff = GAIN_MAX;
        else
            target_eff = target_reg;

        if (step_reg == 16'd0)
            step_eff = 16'd1;
        else if (step_reg > STEP_MAX)
            step_eff = STEP_MAX;
        else
            step_eff = step_reg;

        shift_small = (shift_reg >= -BYPASS_LIM) && (shift_reg <= BYPASS_LIM);
        bypass_now  = (gain_reg == target_eff) && shift_small;
    end

    // linear ramp without overshoot
    always_comb
    begin
        gain_gap = '0;
        gain_new = gain_reg;
        if (gain_reg < target_eff)
        begin
            gain_gap = 17'(target_eff) - 17'(gain_reg);
            gain_new = (gain_gap > 17'(step_eff)) ? 16'(gain_reg + step_eff) : target_eff;
        end
        else if (gain_reg > target_eff)
        begin
            gain_gap = 17'(gain_reg) - 17'(target_eff);
            gain_new = (gain_gap > 17'(step_eff)) ? 16'(gain_reg - step_eff) : target_eff;
        end
    end

    // band arithmetic
    always_comb
    begin
        xs     = MW'(x_reg) <<< F;
        diff   = DW'(xs) - DW'(m_reg);
        hp     = DW'(xs) - DW'(lp_reg);
        // m + floor((alpha*diff + 2^15) / 2^16)
        lp_sum = DW'(m_reg) + mul_p[PW-1:16] + DW'(mul_p[15]);
        // truncate toward zero, then saturate
        rnd    = acc_reg + (acc_reg[AW-1] ? BIAS : '0);
        scaled = rnd[AW-1:SH];
        if (scaled > SAT_HI)
            sat_out = SAT_HI[15:0];
        else if (scaled < SAT_LO)
            sat_out = SAT_LO[15:0];
        else
            sat_out = scaled[15:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = diff;
        mul_b      = alpha_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = bypass_now ? ST_FIN : ST_RAMP;
            end
            ST_RAMP:
            begin
                // low-band update and reciprocal run side by side
                mul_start  = 1'b1;
                div_start  = 1'b1;
                state_next = ST_W1;
            end
            ST_W1:
            begin
                if (mul_st.done)
                    state_next = ST_LP;
            end
            ST_LP:
            begin
                mul_start  = 1'b1;
                mul_a      = DW'(signed'(lp_sum[MW-1:0]));
                mul_b      = inv;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = hp;
                    mul_b      = gain_reg;
                    state_next = ST_W3;
                end
            end
            ST_W3:
            begin
                if (mul_st.done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration and channel bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            target_reg    <= GAIN_UNITY;
            step_reg      <= STEP_RST;
            chan_reg      <= 4'd1;
            valid_reg     <= '0;
            pos_reg       <= '0;
            gain_reg      <= GAIN_UNITY;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SHIFT:       shift_reg  <= signed'(cfg_data[8:0]);
                    CFG_GAIN_TARGET: target_reg <= cfg_data;
                    CFG_RAMP_STEP:   step_reg   <= cfg_data;
                    CFG_CHANNELS:
                    begin
                        chan_reg <= cfg_data[3:0];
                        // a new effective count drops all channel history
                        if (eff_count(cfg_data[3:0]) != nch)
                        begin
                            valid_reg <= '0;
                            pos_reg   <= '0;
                        end
                    end
                    default:
                    begin
                        shift_reg <= shift_reg;
                    end
                endcase
            end

            if (accept)
            begin
                pos_reg    <= pos_after;
                bypass_reg <= bypass_now;
            end

            if (state_reg == ST_RAMP)
                gain_reg <= gain_new;

            if (state_reg == ST_LP)
                valid_reg[c_reg] <= 1'b1;

            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= signed'(s_tdata);
            c_reg     <= c_now;
            m_reg     <= valid_reg[c_now] ? signed'(mem_reg[c_now]) : '0;
            alpha_reg <= (shift_reg > 9'sd0) ? ALPHA_POS : ALPHA_NEG;
        end
        if (state_reg == ST_LP)
        begin
            lp_reg         <= signed'(lp_sum[MW-1:0]);
            mem_reg[c_reg] <= lp_sum[MW-1:0];
        end
        if (state_reg == ST_W2 && mul_st.done)
            prod_reg <= mul_p;
        if (state_reg == ST_W3 && mul_st.done)
            acc_reg <= AW'(prod_reg) + AW'(mul_p);
        if (state_reg == ST_FIN && out_free)
            out_data_reg <= bypass_reg ? x_reg : sat_out;
    end

    ftsf_smul #(
        .WA (DW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_st),
        .p     (mul_p)
    );

    ftsf_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (gain_new),
        .stat     (div_st),
        .quotient (inv)
    );

    // the gain never leaves its legal range
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gain_reg >= GAIN_MIN) && (gain_reg <= GAIN_MAX))
        else $error("gain out of range");

    // reciprocal is finished whenever the first product is
    a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W1 && mul_st.done) |-> !div_st.busy)
        else $error("reciprocal not ready");

    // a bypassed sample goes straight to the output stage and keeps the gain
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bypass_now) |=> (state_reg == ST_FIN && $stable(gain_reg)))
        else $error("bypass path disturbed");

    // the multiplier only reports completion while a product is awaited
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_st.done |-> (state_reg == ST_W1 || state_reg == ST_W2 || state_reg == ST_W3))
        else $error("unexpected multiplier completion");

endmodule

`default_nettype wire

// File: dv/formant_tilt_shelf_filter_top_test.sv
// ----------------------------------------------------------------------------
// formant_tilt_shelf_filter_top_test: tilt shelving filter testbench
// drives interleaved samples under several register settings, predicts each
// filtered or passed-through sample and compares it with the block's output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module formant_tilt_shelf_filter_top_test;
    import ftsf_pkg::*;

    localparam int NCH      = 8;
    localparam int FRAC     = 8;
    localparam int WDOG_MAX = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = CFG_SHIFT;
    logic [15:0] cfg_data = '0;

    formant_tilt_shelf_filter_top uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state and register copies
    longint            lp_mem [NCH];
    int unsigned       gain_now;
    int unsigned       chan_pos;
    int                reg_shift;
    int unsigned       reg_target;
    int unsigned       reg_step;
    int unsigned       reg_chans;

    logic [15:0]       expected_samples [$];
    int                errors = 0;
    int                idle_cycles = 0;
    bit                rx_hold = 1'b0;   // long receiver hold-off
    bit                rx_free = 1'b0;   // receiver never idles

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned active_channels();
        return clampu(reg_chans, 1, NCH);
    endfunction

    // floor division by 2^s
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint trunc_sh(longint v, int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    // works out the filtered or passed-through sample and advances the filter state
    function automatic logic [15:0] shelf_filter(logic signed [15:0] x_in);
        longint      x, xs, lpv, hpv, acc, res, alpha;
        int          sh;
        int unsigned tgt, stp, nch, c, g, inv;
        x   = x_in;
        sh  = reg_shift < -192 ? -192 : (reg_shift > 192 ? 192 : reg_shift);
        tgt = clampu(reg_target, GAIN_MIN, GAIN_MAX);
        stp = clampu(reg_step, 1, STEP_MAX);
        nch = active_channels();
        if (chan_pos >= nch)
            chan_pos = 0;
        c = chan_pos;
        if (gain_now == tgt && sh >= -BYPASS_LIM && sh <= BYPASS_LIM)
            res = x;
        else
        begin
            alpha = sh > 0 ? ALPHA_POS : ALPHA_NEG;
            if (gain_now < tgt)
                gain_now = (tgt - gain_now > stp) ? gain_now + stp : tgt;
            else if (gain_now > tgt)
                gain_now = (gain_now - tgt > stp) ? gain_now - stp : tgt;
            g   = clampu(gain_now, GAIN_MIN, GAIN_MAX);
            inv = 32'(((64'd1 << 28) + g / 2) / g);
            xs  = x * (64'sd1 << FRAC);
            lpv = lp_mem[c] + floor_sh(alpha * (xs - lp_mem[c]) + 32768, 16);
            lp_mem[c] = lpv;
            hpv = xs - lpv;
            acc = lpv * longint'(inv) + hpv * longint'(g);
            res = trunc_sh(acc, FRAC + 14);
            if (res > 32767)
                res = 32767;
            if (res < -32768)
                res = -32768;
        end
        chan_pos = (c + 1 >= nch) ? 0 : c + 1;
        return res[15:0];
    endfunction

    function automatic void predictor_reset();
        foreach (lp_mem[i])
            lp_mem[i] = 0;
        gain_now   = GAIN_UNITY;
        chan_pos   = 0;
        reg_shift  = 0;
        reg_target = GAIN_UNITY;
        reg_step   = STEP_RST;
        reg_chans  = 1;
    endfunction

    // wait for every expected sample, then let a filtered sample drain
    task automatic drain();
        wait (expected_samples.size() == 0);
        repeat (80) @(negedge clk);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        int unsigned prev;
        drain();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_SHIFT:       reg_shift  = $signed(value[8:0]);
            CFG_GAIN_TARGET: reg_target = value;
            CFG_RAMP_STEP:   reg_step   = value;
            CFG_CHANNELS:
            begin
                prev      = active_channels();
                reg_chans = value[3:0];
                if (active_channels() != prev)
                begin
                    foreach (lp_mem[i])
                        lp_mem[i] = 0;
                    chan_pos = 0;
                end
            end
            default:
            begin
                reg_shift = reg_shift;
            end
        endcase
    endtask

    // send one sample, with a random gap when asked
    task automatic send_sample(logic [15:0] value, bit gaps = 1'b1);
        if (gaps)
            repeat ($urandom_range(0, 9)) @(negedge clk);
        s_tdata  = value;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_samples.push_back(shelf_filter(value));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // random sample, biased toward extremes now and then
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes, bypass, ramp up and down, clamped registers
    task automatic test_directed();
        logic [15:0] edges [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5A5A};
        foreach (edges[i])
            send_sample(edges[i]);                  // settled bypass
        write_reg(CFG_SHIFT, 16'd8);                 // bypass edge, still settled
        send_sample(16'h1234);
        write_reg(CFG_SHIFT, 16'h01F7);              // -9: filter, negative alpha
        for (int i = 0; i < 4; i++)
            send_sample(edges[i]);
        write_reg(CFG_GAIN_TARGET, 16'hFFFF);        // clamps to max
        write_reg(CFG_RAMP_STEP, 16'd0);             // zero step counts as 1
        write_reg(CFG_SHIFT, 16'd192);               // positive alpha, ramping
        for (int i = 0; i < 4; i++)
            send_sample(edges[i]);
        write_reg(CFG_RAMP_STEP, 16'hFFFF);          // clamps to max step
        write_reg(CFG_GAIN_TARGET, 16'd0);           // clamps to min
        write_reg(CFG_SHIFT, 16'h0100);              // -256 clamps to -192
        for (int i = 0; i < 4; i++)
            send_sample(edges[i]);
        write_reg(CFG_SHIFT, 16'd0);                 // settled at min, bypass
        send_sample(16'h7FFF);
    endtask

    // random samples under one register setting
    task automatic test_random_phase(int n);
        write_reg(CFG_SHIFT, 16'($urandom_range(0, 511)));
        write_reg(CFG_GAIN_TARGET, 16'($urandom));
        write_reg(CFG_RAMP_STEP, $urandom_range(0, 1) ? 16'($urandom_range(0, 2000))
                                                      : 16'($urandom));
        write_reg(CFG_CHANNELS, 16'($urandom_range(0, 15)));
        for (int i = 0; i < n; i++)
            send_sample(rand_sample(), i % 50 < 40);
    endtask

    // receiver holds off while the sender keeps offering samples
    task automatic test_backpressure();
        write_reg(CFG_SHIFT, 16'd100);
        write_reg(CFG_CHANNELS, 16'd8);
        rx_hold = 1'b1;
        fork
            for (int i = 0; i < 20; i++)
                send_sample(rand_sample(), 1'b0);
            begin
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
        join
        // sender pauses until everything is back
        wait (expected_samples.size() == 0);
        rx_free = 1'b1;
        for (int i = 0; i < 20; i++)
            send_sample(rand_sample(), 1'b0);
        rx_free = 1'b0;
    endtask

    initial
    begin
        predictor_reset();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        for (int p = 0; p < 16; p++)
            test_random_phase(100);
        write_reg(CFG_CHANNELS, 16'd0);
        test_random_phase(20);
        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver ready pattern
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                m_tready = 1'b0;
            else if (rx_free)
                m_tready = 1'b1;
            else if (m_tready && !m_tvalid)
                m_tready = 1'b1;
            else if ($urandom_range(0, 9) < 4)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge clk);
                m_tready = 1'b1;
            end
            else
                m_tready = 1'b1;
        end
    end

    // result check against the oldest expected sample
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                if (m_tdata !== expected_samples[0])
                begin
                    $error("sample_out: expected %h actual %h", expected_samples[0], m_tdata);
                    errors++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // watchdog on cycles with no request accepted anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

`default_nettype wire
